// ===== rtl/abt_pkg.sv =====
// Shared types and codes for the address binding table.
// No dependencies.
package abt_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_FIND_KEY = 2'd2,
    OP_FIND_ADDR = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RC_DONE = 2'd0,
    RC_NOT_FOUND = 2'd1,
    RC_PRESENT = 2'd2,
    RC_FULL = 2'd3
  } rc_e;

  localparam int unsigned KeyW = 22;
  localparam int unsigned LenW = 5;
  localparam int unsigned GrpW = 48;

  typedef struct packed {
    logic [1:0] operation;
    logic [KeyW-1:0] device_number;
    logic [LenW-1:0] address_length;
    logic [GrpW-1:0] address_bytes_lo;
    logic [GrpW-1:0] address_bytes_mid;
    logic [GrpW-1:0] address_bytes_hi;
  } req_t;

  typedef struct packed {
    logic [1:0] result_code;
    logic [KeyW-1:0] found_device_number;
    logic [LenW-1:0] found_length;
    logic [GrpW-1:0] found_bytes_lo;
    logic [GrpW-1:0] found_bytes_mid;
    logic [GrpW-1:0] found_bytes_hi;
    logic [LenW-1:0] entry_count;
  } rsp_t;

  // Mask keeping the first n bytes of six-byte group seg.
  function automatic logic [GrpW-1:0] group_mask(input logic [LenW-1:0] n,
                                                 input logic [1:0] seg);
    logic [GrpW-1:0] m;
    m = '0;
    for (int b = 0; b < 6; b++) begin
      if (32'(n) > 32'(seg) * 6 + b) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction
endpackage

// ===== rtl/abt_if.sv =====
// Valid/ready channels carrying one request word (req_t) or one response word (rsp_t).
// Depends on abt_pkg for payload types.
interface abt_req_if;
  logic valid;
  logic ready;
  abt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abt_rsp_if;
  logic valid;
  logic ready;
  abt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/abt_front.sv =====
// Front end: accept request words, mask address bytes, queue two deep.
// Depends on abt_pkg and abt_if.
module abt_front #(
  parameter int unsigned ADDRESS_BYTES_MAX = 18
) (
  input  logic clk_i,
  input  logic rst_ni,
  abt_req_if.sink   in_i,
  output logic           q_valid_o,
  output abt_pkg::req_t  q_data_o,
  input  logic           q_pop_i
);
  abt_pkg::req_t mem_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_q, rd_q;
  abt_pkg::req_t clean;
  logic [abt_pkg::LenW-1:0] n;
  logic push;

  assign in_i.ready = (cnt_q != 2'd2);
  assign push = in_i.valid && in_i.ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_data_o = mem_q[rd_q];

  always_comb begin
    n = (32'(in_i.data.address_length) > ADDRESS_BYTES_MAX) ?
        abt_pkg::LenW'(ADDRESS_BYTES_MAX) : in_i.data.address_length;
    clean = in_i.data;
    clean.address_bytes_lo = in_i.data.address_bytes_lo & abt_pkg::group_mask(n, 2'd0);
    clean.address_bytes_mid = in_i.data.address_bytes_mid & abt_pkg::group_mask(n, 2'd1);
    clean.address_bytes_hi = in_i.data.address_bytes_hi & abt_pkg::group_mask(n, 2'd2);
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= clean;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_q <= 1'b0;
      rd_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
    end
  end
endmodule

// ===== rtl/abt_back.sv =====
// Back end: scan the table one entry a cycle, write back, emit result word.
// Depends on abt_pkg and abt_if.
module abt_back #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic           q_valid_i,
  input  abt_pkg::req_t  q_data_i,
  output logic           q_pop_o,
  abt_rsp_if.source      out_o,
  output logic [abt_pkg::LenW-1:0] count_o
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DONE = 4'b0100,
    ST_OUT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  abt_pkg::req_t req_q;
  logic [CntW-1:0] idx_q;
  logic [TABLE_ENTRIES-1:0] valid_q;
  logic [abt_pkg::KeyW-1:0] key_m [TABLE_ENTRIES];
  logic [abt_pkg::LenW-1:0] len_m [TABLE_ENTRIES];
  logic [abt_pkg::GrpW-1:0] lo_m [TABLE_ENTRIES];
  logic [abt_pkg::GrpW-1:0] mid_m [TABLE_ENTRIES];
  logic [abt_pkg::GrpW-1:0] hi_m [TABLE_ENTRIES];
  logic [abt_pkg::LenW-1:0] count_q;
  logic hit_q, free_q;
  logic [IdxW-1:0] hit_idx_q, free_idx_q;
  logic [abt_pkg::KeyW-1:0] best_key_q;
  logic [IdxW-1:0] cur;
  logic match;
  logic [IdxW-1:0] rd_idx;
  abt_pkg::rsp_t rsp_q, rsp_d;

  assign cur = idx_q[IdxW-1:0];
  assign count_o = count_q;
  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;
  assign out_o.valid = (state_q == ST_OUT);
  assign out_o.data = rsp_q;

  always_comb begin
    if (abt_pkg::op_e'(req_q.operation) == abt_pkg::OP_FIND_ADDR)
      match = valid_q[cur] && (req_q.address_length != '0) &&
              (len_m[cur] == req_q.address_length) &&
              (lo_m[cur] == req_q.address_bytes_lo) &&
              (mid_m[cur] == req_q.address_bytes_mid) &&
              (hi_m[cur] == req_q.address_bytes_hi) &&
              (!hit_q || key_m[cur] > best_key_q);
    else
      match = valid_q[cur] && !hit_q && (key_m[cur] == req_q.device_number);
    rd_idx = hit_q ? hit_idx_q : free_idx_q;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (q_valid_i) state_d = ST_SCAN;
      ST_SCAN: if (32'(idx_q) == TABLE_ENTRIES - 1) state_d = ST_DONE;
      ST_DONE: state_d = ST_OUT;
      ST_OUT:  if (out_o.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rsp_d = '0;
    rsp_d.entry_count = count_q;
    if (hit_q) begin
      rsp_d.found_device_number = key_m[rd_idx];
      rsp_d.found_length = len_m[rd_idx];
      rsp_d.found_bytes_lo = lo_m[rd_idx];
      rsp_d.found_bytes_mid = mid_m[rd_idx];
      rsp_d.found_bytes_hi = hi_m[rd_idx];
    end
    unique case (abt_pkg::op_e'(req_q.operation))
      abt_pkg::OP_ADD: begin
        if (hit_q) rsp_d.result_code = abt_pkg::RC_PRESENT;
        else if (!free_q) rsp_d.result_code = abt_pkg::RC_FULL;
        else begin
          rsp_d.result_code = abt_pkg::RC_DONE;
          rsp_d.entry_count = count_q + 1'b1;
          rsp_d.found_device_number = req_q.device_number;
          rsp_d.found_length = req_q.address_length;
          rsp_d.found_bytes_lo = req_q.address_bytes_lo;
          rsp_d.found_bytes_mid = req_q.address_bytes_mid;
          rsp_d.found_bytes_hi = req_q.address_bytes_hi;
        end
      end
      abt_pkg::OP_DEL: begin
        rsp_d.result_code = hit_q ? abt_pkg::RC_DONE : abt_pkg::RC_NOT_FOUND;
        if (hit_q) rsp_d.entry_count = count_q - 1'b1;
      end
      default: rsp_d.result_code = hit_q ? abt_pkg::RC_DONE : abt_pkg::RC_NOT_FOUND;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) req_q <= q_data_i;
    if (state_q == ST_SCAN && match) best_key_q <= key_m[cur];
    if (state_q == ST_DONE && abt_pkg::op_e'(req_q.operation) == abt_pkg::OP_ADD &&
        !hit_q && free_q) begin
      key_m[free_idx_q] <= req_q.device_number;
      len_m[free_idx_q] <= req_q.address_length;
      lo_m[free_idx_q] <= req_q.address_bytes_lo;
      mid_m[free_idx_q] <= req_q.address_bytes_mid;
      hi_m[free_idx_q] <= req_q.address_bytes_hi;
    end
    if (state_q == ST_DONE) rsp_q <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q <= '0;
      valid_q <= '0;
      count_q <= '0;
      hit_q <= 1'b0;
      free_q <= 1'b0;
      hit_idx_q <= '0;
      free_idx_q <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          hit_q <= 1'b0;
          free_q <= 1'b0;
        end
        ST_SCAN: begin
          idx_q <= idx_q + 1'b1;
          if (match) begin
            hit_q <= 1'b1;
            hit_idx_q <= cur;
          end
          if (!valid_q[cur] && !free_q) begin
            free_q <= 1'b1;
            free_idx_q <= cur;
          end
        end
        ST_DONE: begin
          if (abt_pkg::op_e'(req_q.operation) == abt_pkg::OP_ADD && !hit_q && free_q) begin
            valid_q[free_idx_q] <= 1'b1;
            count_q <= count_q + 1'b1;
          end
          if (abt_pkg::op_e'(req_q.operation) == abt_pkg::OP_DEL && hit_q) begin
            valid_q[hit_idx_q] <= 1'b0;
            count_q <= count_q - 1'b1;
          end
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/address_binding_table.sv =====
// Address binding table: binds 22-bit device numbers to addresses of up to
// ADDRESS_BYTES_MAX bytes, with add, delete, find by key and find by address.
// Each word leaves the input queue, is matched in a sequential scan of every
// table entry, is written back and has its result presented; a new word is
// taken only once the result is accepted, and a stalled output holds the result
// for as long as the stall lasts. A two-word queue in front keeps accepting
// until full while a result waits. Depends on abt_pkg, abt_if, abt_front, abt_back.
module address_binding_table #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned ADDRESS_BYTES_MAX = 18
) (
  input logic clk_i,
  input logic rst_ni,
  abt_req_if.sink   in_i,
  abt_rsp_if.source out_o
);
  logic q_valid, q_pop;
  abt_pkg::req_t q_data;
  logic [abt_pkg::LenW-1:0] count;

  abt_front #(.ADDRESS_BYTES_MAX(ADDRESS_BYTES_MAX)) u_front (
    .clk_i, .rst_ni, .in_i,
    .q_valid_o(q_valid), .q_data_o(q_data), .q_pop_i(q_pop)
  );

  abt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_data_i(q_data), .q_pop_o(q_pop),
    .out_o, .count_o(count)
  );

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count) <= TABLE_ENTRIES) else $error("entry count overflow");
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty queue");
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 ((count == $past(count)) || (count == $past(count) + 1'b1) ||
         (count == $past(count) - 1'b1)))
    else $error("count step");
  a_out_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.data.entry_count == count) else $error("count mismatch");
`endif
endmodule
